@@ rtl/scm_pkg.sv @@
package scm_pkg;

  localparam int MaxN     = 32;
  localparam int MaxNnz   = 1024;
  localparam int NW       = $clog2(MaxN + 1);   // 6: holds 0..MaxN
  localparam int IW       = $clog2(MaxN);       // 5: row/col index
  localparam int PW       = $clog2(MaxNnz + 1); // 11: entry pointer / fill
  localparam int AW       = $clog2(MaxNnz);     // 10: memory address
  localparam int VW       = 16;
  localparam int SW       = 37;

  localparam logic [1:0] ReqClear   = 2'd0;
  localparam logic [1:0] ReqLoadA   = 2'd1;
  localparam logic [1:0] ReqLoadB   = 2'd2;
  localparam logic [1:0] ReqCompute = 2'd3;

  typedef struct packed {
    logic in_ready;
    logic cap;
    logic clear;
    logic load;
    logic row_init;
    logic j_start;
    logic step;
    logic take;
    logic j_inc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic       in_valid;
    logic [1:0] req;
    logic       row_ge_n;
    logic       merge_done;
    logic       acc_nz;
    logic       pend_v;
    logic       out_busy;
    logic       j_last;
  } sts_t;

  // size register value as used: 0 acts as 1, above MaxN acts as MaxN
  function automatic logic [NW-1:0] size_use(input logic [5:0] sz);
    logic [NW-1:0] r;
    if (sz == 6'd0) r = NW'(1);
    else if (32'(sz) > MaxN) r = NW'(MaxN);
    else r = NW'(sz);
    return r;
  endfunction

endpackage

@@ rtl/scm_if.sv @@
interface scm_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [4:0]        row_index;
  logic [4:0]        col_index;
  logic signed [15:0] value;
  modport source (output valid, req_type, row_index, col_index, value, input ready);
  modport sink (input valid, req_type, row_index, col_index, value, output ready);
endinterface

interface scm_rsp_if;
  logic              valid;
  logic              ready;
  logic [4:0]        out_row;
  logic [4:0]        out_col;
  logic signed [36:0] out_value;
  logic              has_value;
  logic              last;
  modport source (output valid, out_row, out_col, out_value, has_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, has_value, last, output ready);
endinterface

interface scm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/sparse_csr_matrix_multiply.sv @@
// Clear and load items: one item at a time.
// Compute item: per column j of the result, merge steps (one entry-memory read, then
// compare); at most 63 steps a column. A row at or beyond matrix_size goes straight
// to the final output. Output stalls can hold the merge between columns and at the end.
// Results leave through an output register; the held result is released when the
// next nonzero is found or the row ends. Reset (rst_ni low, async) empties both, size 32.
module sparse_csr_matrix_multiply (
  input  logic      clk_i,
  input  logic      rst_ni,
  scm_req_if.sink   in_i,
  scm_rsp_if.source out_o,
  scm_cfg_if.sink   cfg_i
);
  import scm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  scm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  scm_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .in_i   (in_i),
    .out_o  (out_o),
    .cfg_i  (cfg_i)
  );

endmodule

@@ rtl/scm_datapath.sv @@
module scm_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scm_pkg::cmd_t cmd_i,
  output scm_pkg::sts_t sts_o,
  scm_req_if.sink       in_i,
  scm_rsp_if.source     out_o,
  scm_cfg_if.sink       cfg_i
);
  import scm_pkg::*;

  logic [5:0]           size_q;
  logic [1:0]           req_q;
  logic [IW-1:0]        row_q, col_q;
  logic signed [VW-1:0] val_q;

  logic [PW-1:0] a_fill_q, b_fill_q;
  logic [IW-1:0] a_lrow_q, a_lcol_q, b_lrow_q, b_lcol_q;
  // entry k-1 holds the start of row k; row 0 always starts at 0
  logic [PW-1:0] a_rs_q [MaxN];
  logic [PW-1:0] b_rs_q [MaxN];

  logic [IW+VW-1:0] a_mem [MaxNnz];
  logic [IW+VW-1:0] b_mem [MaxNnz];
  logic [IW+VW-1:0] a_rd_q, b_rd_q;

  logic [PW-1:0] ka_q, ka0_q, kend_q, lb_q, lf_q;
  logic [IW-1:0] j_q;
  logic signed [2*VW-1:0] prod_q;
  logic                   prod_v_q;
  logic signed [SW-1:0]   acc_q;

  logic                 pend_v_q;
  logic [IW-1:0]        pend_col_q;
  logic signed [SW-1:0] pend_val_q;

  logic                 out_v_q, out_has_q, out_last_q;
  logic [IW-1:0]        out_row_q;
  logic [IW-1:0]        out_col_q;
  logic signed [SW-1:0] out_val_q;

  logic [NW-1:0] n;
  logic          in_range, a_ok, b_ok, push;
  logic [NW-1:0] j_nx;

  assign n        = size_use(size_q);
  assign in_range = ({1'b0, row_q} < n) && ({1'b0, col_q} < n);
  assign a_ok = cmd_i.load && (req_q == ReqLoadA) && in_range && (a_fill_q < PW'(MaxNnz)) &&
                ((a_fill_q == '0) || (row_q > a_lrow_q) ||
                 ((row_q == a_lrow_q) && (col_q > a_lcol_q)));
  assign b_ok = cmd_i.load && (req_q == ReqLoadB) && in_range && (b_fill_q < PW'(MaxNnz)) &&
                ((b_fill_q == '0) || (row_q > b_lrow_q) ||
                 ((row_q == b_lrow_q) && (col_q > b_lcol_q)));
  assign j_nx   = {1'b0, j_q} + NW'(1);
  assign push   = (cmd_i.take && pend_v_q) || cmd_i.fin;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = cmd_i.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 6'd32;
    end else if (cfg_i.valid) begin
      size_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= in_i.req_type;
      row_q <= in_i.row_index;
      col_q <= in_i.col_index;
      val_q <= in_i.value;
    end
  end

  // fill counts and row-start tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_fill_q <= '0;
      b_fill_q <= '0;
      for (int k = 0; k < MaxN; k++) begin
        a_rs_q[k] <= '0;
        b_rs_q[k] <= '0;
      end
    end else if (cmd_i.clear) begin
      a_fill_q <= '0;
      b_fill_q <= '0;
      for (int k = 0; k < MaxN; k++) begin
        a_rs_q[k] <= '0;
        b_rs_q[k] <= '0;
      end
    end else begin
      if (a_ok) begin
        a_fill_q <= a_fill_q + PW'(1);
        for (int k = 1; k <= MaxN; k++) begin
          if (k > int'(row_q)) a_rs_q[k-1] <= a_fill_q + PW'(1);
        end
      end
      if (b_ok) begin
        b_fill_q <= b_fill_q + PW'(1);
        for (int k = 1; k <= MaxN; k++) begin
          if (k > int'(row_q)) b_rs_q[k-1] <= b_fill_q + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ok) begin
      a_lrow_q <= row_q;
      a_lcol_q <= col_q;
      a_mem[a_fill_q[AW-1:0]] <= {col_q, val_q};
    end
    if (b_ok) begin
      b_lrow_q <= row_q;
      b_lcol_q <= col_q;
      b_mem[b_fill_q[AW-1:0]] <= {col_q, val_q};
    end
    a_rd_q <= a_mem[ka_q[AW-1:0]];
    b_rd_q <= b_mem[lb_q[AW-1:0]];
  end

  // merge pointers and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      ka0_q  <= (row_q == '0) ? '0 : a_rs_q[row_q - IW'(1)];
      kend_q <= a_rs_q[row_q];
      j_q    <= '0;
    end
    if (cmd_i.j_inc) j_q <= j_q + IW'(1);
    if (cmd_i.j_start) begin
      ka_q <= ka0_q;
      lb_q <= (j_q == '0) ? '0 : b_rs_q[j_q - IW'(1)];
      lf_q <= b_rs_q[j_q];
    end else if (cmd_i.step) begin
      if (a_rd_q[IW+VW-1:VW] < b_rd_q[IW+VW-1:VW]) begin
        ka_q <= ka_q + PW'(1);
      end else if (a_rd_q[IW+VW-1:VW] > b_rd_q[IW+VW-1:VW]) begin
        lb_q <= lb_q + PW'(1);
      end else begin
        ka_q <= ka_q + PW'(1);
        lb_q <= lb_q + PW'(1);
      end
    end
    prod_q <= $signed(a_rd_q[VW-1:0]) * $signed(b_rd_q[VW-1:0]);
    if (cmd_i.j_start) acc_q <= '0;
    else if (prod_v_q) acc_q <= acc_q + SW'(prod_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.step && (a_rd_q[IW+VW-1:VW] == b_rd_q[IW+VW-1:VW]);
      if (cmd_i.cap) pend_v_q <= 1'b0;
      else if (cmd_i.take) pend_v_q <= 1'b1;
      if (push) out_v_q <= 1'b1;
      else if (out_o.ready) out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pend_col_q <= j_q;
      pend_val_q <= acc_q;
    end
    if (push) begin
      out_row_q  <= row_q;
      out_has_q  <= pend_v_q;
      out_last_q <= cmd_i.fin;
      out_col_q  <= pend_v_q ? pend_col_q : '0;
      out_val_q  <= pend_v_q ? pend_val_q : '0;
    end
  end

  assign out_o.valid     = out_v_q;
  assign out_o.out_row   = out_row_q;
  assign out_o.out_col   = out_col_q;
  assign out_o.out_value = out_val_q;
  assign out_o.has_value = out_has_q;
  assign out_o.last      = out_last_q;

  assign sts_o.in_valid   = in_i.valid;
  assign sts_o.req        = req_q;
  assign sts_o.row_ge_n   = ({1'b0, row_q} >= n);
  assign sts_o.merge_done = (ka_q >= kend_q) || (lb_q >= lf_q);
  assign sts_o.acc_nz     = (acc_q != '0);
  assign sts_o.pend_v     = pend_v_q;
  assign sts_o.out_busy   = out_v_q && !out_o.ready;
  assign sts_o.j_last     = (j_nx == n);

endmodule

@@ rtl/scm_ctrl.sv @@
module scm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scm_pkg::sts_t sts_i,
  output scm_pkg::cmd_t cmd_o
);
  import scm_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDisp  = 3'd1;
  localparam logic [2:0] StRow   = 3'd2;
  localparam logic [2:0] StJBeg  = 3'd3;
  localparam logic [2:0] StRead  = 3'd4;
  localparam logic [2:0] StCmp   = 3'd5;
  localparam logic [2:0] StJDone = 3'd6;
  localparam logic [2:0] StFin   = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.cap = 1'b1;
          state_d   = StDisp;
        end
      end
      StDisp: begin
        case (sts_i.req)
          ReqClear: begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
          ReqLoadA, ReqLoadB: begin
            cmd_o.load = 1'b1;
            state_d    = StIdle;
          end
          default: state_d = sts_i.row_ge_n ? StFin : StRow;
        endcase
      end
      StRow: begin
        cmd_o.row_init = 1'b1;
        state_d        = StJBeg;
      end
      StJBeg: begin
        cmd_o.j_start = 1'b1;
        state_d       = StRead;
      end
      StRead: state_d = sts_i.merge_done ? StJDone : StCmp;
      StCmp: begin
        cmd_o.step = 1'b1;
        state_d    = StRead;
      end
      StJDone: begin
        // a new nonzero pushes the held one out, so wait for room first
        if (!(sts_i.acc_nz && sts_i.pend_v && sts_i.out_busy)) begin
          cmd_o.take = sts_i.acc_nz;
          if (sts_i.j_last) begin
            state_d = StFin;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = StJBeg;
          end
        end
      end
      StFin: begin
        if (!sts_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
